// ----- src/alu16f_pkg.sv -----
// Package: operation codes, status-word bit positions and word types of the 16-bit ALU.
`timescale 1ns / 1ps

package alu16f_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned OP_W   = 5;
  localparam int unsigned OFFS_W = 10;

  // status-word flag positions
  localparam int unsigned SR_C = 0;
  localparam int unsigned SR_Z = 1;
  localparam int unsigned SR_N = 2;
  localparam int unsigned SR_V = 8;

  typedef enum logic [OP_W-1:0] {
    OP_MOV  = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_CMP  = 5'd3,
    OP_DADD = 5'd4,
    OP_BIT  = 5'd5,
    OP_BIC  = 5'd6,
    OP_BIS  = 5'd7,
    OP_XOR  = 5'd8,
    OP_AND  = 5'd9,
    OP_RRC  = 5'd10,
    OP_RRA  = 5'd11,
    OP_SWPB = 5'd12,
    OP_SXT  = 5'd13,
    OP_JNE  = 5'd14,
    OP_JEQ  = 5'd15,
    OP_JNC  = 5'd16,
    OP_JC   = 5'd17,
    OP_JN   = 5'd18,
    OP_JGE  = 5'd19,
    OP_JL   = 5'd20,
    OP_JMP  = 5'd21
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic                     byte_mode;
    logic [DATA_W-1:0]        src_value;
    logic [DATA_W-1:0]        dst_value;
    logic [DATA_W-1:0]        sr_in;
    logic [DATA_W-1:0]        instr_addr;
    logic signed [OFFS_W-1:0] jump_offset;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              write_result;
    logic [DATA_W-1:0] sr_out;
    logic              branch_taken;
    logic [DATA_W-1:0] branch_target;
  } alu_rsp_t;

endpackage

// ----- src/alu16f_req_if.sv -----
// Request channel of the 16-bit ALU: valid/ready and the instruction word.
`timescale 1ns / 1ps

interface alu16f_req_if import alu16f_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          req_type;
  logic                     byte_mode;
  logic [DATA_W-1:0]        src_value;
  logic [DATA_W-1:0]        dst_value;
  logic [DATA_W-1:0]        sr_in;
  logic [DATA_W-1:0]        instr_addr;
  logic signed [OFFS_W-1:0] jump_offset;

  modport source (
    output valid, req_type, byte_mode, src_value, dst_value, sr_in, instr_addr,
           jump_offset,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_mode, src_value, dst_value, sr_in, instr_addr,
           jump_offset,
    output ready
  );
endinterface

// ----- src/alu16f_rsp_if.sv -----
// Response channel of the 16-bit ALU: valid/ready and the result word.
`timescale 1ns / 1ps

interface alu16f_rsp_if import alu16f_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              write_result;
  logic [DATA_W-1:0] sr_out;
  logic              branch_taken;
  logic [DATA_W-1:0] branch_target;

  modport source (
    output valid, result_value, write_result, sr_out, branch_taken, branch_target,
    input  ready
  );
  modport sink (
    input  valid, result_value, write_result, sr_out, branch_taken, branch_target,
    output ready
  );
endinterface

// ----- src/sixteen_bit_alu_with_flags_core.sv -----
// Top level: registered execute unit of a 16-bit microcontroller with status flags.
//
//  channel | dir | handshake    | word
//  --------+-----+--------------+----------------------------------------------
//  req_i   | in  | valid/ready  | op, byte mode, src, dst, sr, addr, offset
//  rsp_o   | out | valid/ready  | result, write flag, sr, taken, target
//
// Two register stages: input register, then the ALU and flag logic into the
// result register. One word per cycle is sustained while rsp_o is ready; the
// input stage advances whenever the result register is empty or being drained,
// so a stalled rsp_o backs up one stage at a time. Reset clears both valid bits;
// payload registers are not reset.
`timescale 1ns / 1ps

module sixteen_bit_alu_with_flags_core import alu16f_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  alu16f_req_if.sink    req_i,
  alu16f_rsp_if.source  rsp_o
);

  logic     in_vld_q;
  alu_req_t in_q;
  logic     out_vld_q;
  alu_rsp_t out_q;
  alu_rsp_t res_d;

  logic out_free;
  logic in_adv;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign in_adv      = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.req_type    <= req_i.req_type;
      in_q.byte_mode   <= req_i.byte_mode;
      in_q.src_value   <= req_i.src_value;
      in_q.dst_value   <= req_i.dst_value;
      in_q.sr_in       <= req_i.sr_in;
      in_q.instr_addr  <= req_i.instr_addr;
      in_q.jump_offset <= req_i.jump_offset;
    end
  end

  // ALU and flags
  always_comb begin
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] msb;
    logic [DATA_W-1:0] sm;
    logic [DATA_W-1:0] dm;
    logic [DATA_W-1:0] b;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] sro;
    logic              wr;
    logic              taken;
    logic              cin;
    logic              zin;
    logic              nin;
    logic              vin;
    logic              fc;
    logic              fv;
    logic              upd;
    logic [4:0]        dig [4];
    logic [4:0]        carry;
    logic [DATA_W-1:0] dr;
    logic [DATA_W-1:0] offs_x2;

    m   = in_q.byte_mode ? 16'h00ff : 16'hffff;
    msb = in_q.byte_mode ? 16'h0080 : 16'h8000;
    sm  = in_q.src_value & m;
    dm  = in_q.dst_value & m;
    cin = in_q.sr_in[SR_C];
    zin = in_q.sr_in[SR_Z];
    nin = in_q.sr_in[SR_N];
    vin = in_q.sr_in[SR_V];

    // shared adder: ADD uses src, SUB/CMP use the inverted source plus one
    b   = (op_e'(in_q.req_type) == OP_ADD) ? sm : (~sm & m);
    sum = {1'b0, dm} + {1'b0, b} + {{DATA_W{1'b0}}, op_e'(in_q.req_type) != OP_ADD};

    // decimal add, one nibble a step
    carry[0] = cin;
    dr       = '0;
    for (int i = 0; i < 4; i++) begin
      dig[i] = {1'b0, dm[4*i +: 4]} + {1'b0, sm[4*i +: 4]} + {4'd0, carry[i]};
      if (dig[i] > 5'd9) begin
        dig[i]     = dig[i] - 5'd10;
        carry[i+1] = 1'b1;
      end else begin
        carry[i+1] = 1'b0;
      end
      dr[4*i +: 4] = dig[i][3:0];
    end
    dr = dr & m;

    offs_x2 = {{(DATA_W-OFFS_W-1){in_q.jump_offset[OFFS_W-1]}}, in_q.jump_offset, 1'b0};

    r     = '0;
    res   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    upd   = 1'b0;
    fc    = 1'b0;
    fv    = 1'b0;

    unique case (op_e'(in_q.req_type))
      OP_MOV: begin
        res = sm;
        wr  = 1'b1;
      end
      OP_ADD, OP_SUB, OP_CMP: begin
        r   = sum[DATA_W-1:0] & m;
        fc  = in_q.byte_mode ? sum[8] : sum[DATA_W];
        fv  = |((dm ^ r) & (b ^ r) & msb);
        upd = 1'b1;
        if (op_e'(in_q.req_type) != OP_CMP) begin
          res = r;
          wr  = 1'b1;
        end
      end
      OP_DADD: begin
        r   = dr;
        fc  = in_q.byte_mode ? carry[2] : carry[4];
        upd = 1'b1;
        res = r;
        wr  = 1'b1;
      end
      OP_BIT: begin
        r   = dm & sm;
        fc  = |r;
        upd = 1'b1;
      end
      OP_BIC: begin
        res = dm & ~sm & m;
        wr  = 1'b1;
      end
      OP_BIS: begin
        res = dm | sm;
        wr  = 1'b1;
      end
      OP_XOR: begin
        r   = dm ^ sm;
        fc  = |r;
        fv  = |(sm & dm & msb);
        upd = 1'b1;
        res = r;
        wr  = 1'b1;
      end
      OP_AND: begin
        r   = dm & sm;
        fc  = |r;
        upd = 1'b1;
        res = r;
        wr  = 1'b1;
      end
      OP_RRC: begin
        r   = (sm >> 1) | (cin ? msb : '0);
        fc  = sm[0];
        upd = 1'b1;
        res = r;
        wr  = 1'b1;
      end
      OP_RRA: begin
        r   = (sm >> 1) | (sm & msb);
        fc  = sm[0];
        upd = 1'b1;
        res = r;
        wr  = 1'b1;
      end
      OP_SWPB: begin
        res = {in_q.src_value[7:0], in_q.src_value[15:8]};
        wr  = 1'b1;
      end
      OP_SXT: begin
        // always whole word: flags use bit 15 whatever byte_mode says
        r   = {{8{in_q.src_value[7]}}, in_q.src_value[7:0]};
        fc  = |r;
        upd = 1'b1;
        res = r;
        wr  = 1'b1;
      end
      OP_JNE:  taken = !zin;
      OP_JEQ:  taken = zin;
      OP_JNC:  taken = !cin;
      OP_JC:   taken = cin;
      OP_JN:   taken = nin;
      OP_JGE:  taken = (nin == vin);
      OP_JL:   taken = (nin != vin);
      OP_JMP:  taken = 1'b1;
      default: ;
    endcase

    sro = in_q.sr_in;
    if (upd) begin
      sro[SR_C] = fc;
      sro[SR_Z] = (r == '0);
      sro[SR_N] = (op_e'(in_q.req_type) == OP_SXT) ? r[15] : |(r & msb);
      sro[SR_V] = fv;
    end

    res_d.result_value  = res;
    res_d.write_result  = wr;
    res_d.sr_out        = sro;
    res_d.branch_taken  = taken;
    res_d.branch_target = in_q.instr_addr + 16'd2 + offs_x2;
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_q <= res_d;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_value  = out_q.result_value;
  assign rsp_o.write_result  = out_q.write_result;
  assign rsp_o.sr_out        = out_q.sr_out;
  assign rsp_o.branch_taken  = out_q.branch_taken;
  assign rsp_o.branch_target = out_q.branch_target;

  // a jump never writes back, and a result that is not written back is left at zero
  a_wr_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.write_result && out_q.branch_taken))
    else $error("write-back and branch both set");

  a_nowr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.write_result) |-> (out_q.result_value == '0))
    else $error("result not zero without write-back");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> in_vld_q)
    else $error("accepted word lost in input stage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("input taken while both stages are full and stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_o.ready) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
